// ----- hdl/swm_pkg.sv -----
`default_nettype none

package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int OUT_W    = SAMPLE_W + 1;
    localparam int WIN_MAX  = 64;
    localparam int IDX_W    = $clog2(WIN_MAX);
    localparam int CNT_W    = $clog2(WIN_MAX + 1);
    localparam int CFG_W    = 7;
    localparam int WS_RESET = 3;
    localparam int GRP      = 8;
    localparam int GRP_W    = $clog2(GRP);
    localparam int NGRP     = WIN_MAX / GRP;

    typedef logic signed [SAMPLE_W-1:0] smp_t;
    typedef logic signed [OUT_W-1:0]    med_t;

    typedef struct packed {
        logic step;
        logic clr;
        logic rm;
        logic wipe;
    } cell_ctl_t;

    typedef struct packed {
        logic le;
        smp_t v;
    } to_left_t;

    typedef struct packed {
        logic ler;
        logic ev;
        smp_t r;
    } to_right_t;

endpackage

`default_nettype wire

// ----- hdl/swm_in_if.sv -----
`default_nettype none

interface swm_in_if;
    logic          valid;
    logic          ready;
    swm_pkg::smp_t sample;
    logic          first;

    modport source (output valid, output sample, output first, input ready);
    modport sink   (input valid, input sample, input first, output ready);
endinterface

`default_nettype wire

// ----- hdl/swm_out_if.sv -----
`default_nettype none

interface swm_out_if;
    logic          valid;
    logic          ready;
    swm_pkg::med_t median_doubled;

    modport source (output valid, output median_doubled, input ready);
    modport sink   (input valid, input median_doubled, output ready);
endinterface

`default_nettype wire

// ----- hdl/sliding_window_median_core.sv -----
// Running median over the newest window_size signed samples.
// sample_ch (sink): one word per sample; first=1 drops the window and this
// sample opens a new sequence. median_ch (source): one word per sample once
// the window holds window_size samples, carrying twice the median (sum of
// the two middle entries for an even size).
// cfg_we/cfg_wdata write window_size (0 acts as 1, above 64 acts as 64);
// a write also empties the window. Write only while the block is idle.
// Throughput: one sample per cycle while sample_ch.ready is high. A row of
// 64 sorting cells updates in the accept cycle: each cell drops the
// outgoing sample and takes the new one from its neighbors. The outgoing
// sample comes from an arrival ring RAM, read ahead into its output register.
// The result word passes through the cell row, the group select stage and
// the add stage before it is valid on median_ch.
// A stalled receiver holds the output stage; the select stage and the cell
// row each hold one more result, after which sample_ch.ready drops.
// Reset: window empty, window_size = 3, no result pending. No clearing pass.
`default_nettype none

module sliding_window_median_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [swm_pkg::CFG_W-1:0]     cfg_wdata,
    swm_in_if.sink                             sample_ch,
    swm_out_if.source                          median_ch
);

    logic [swm_pkg::CFG_W-1:0] ws_reg;
    logic [swm_pkg::CNT_W-1:0] ws_eff;
    logic [swm_pkg::CNT_W-1:0] fill_reg;
    logic [swm_pkg::CNT_W-1:0] fill_next;
    logic [swm_pkg::CNT_W-1:0] fill_e;
    logic [swm_pkg::IDX_W-1:0] ptr_reg;
    logic [swm_pkg::IDX_W-1:0] ptr_next;
    logic [swm_pkg::IDX_W-1:0] ptr_adv;
    logic [swm_pkg::IDX_W-1:0] waddr;
    logic [swm_pkg::IDX_W-1:0] raddr;
    logic [swm_pkg::IDX_W-1:0] mid_lo;
    logic [swm_pkg::IDX_W-1:0] mid_hi;
    logic                      full;
    logic                      res_flag;
    logic                      in_fire;
    logic                      s1_load;
    logic                      s2_load;
    logic                      r0_v_reg;
    logic                      r0_v_next;
    logic                      s1_v_reg;
    logic                      o_v_reg;
    logic                      byp_reg;
    swm_pkg::smp_t             byp_data_reg;
    swm_pkg::smp_t             rdata;
    swm_pkg::smp_t             old;
    swm_pkg::med_t             o_data_reg;
    swm_pkg::cell_ctl_t        ctl;
    swm_pkg::to_left_t         tl    [swm_pkg::WIN_MAX];
    swm_pkg::to_right_t        tr    [swm_pkg::WIN_MAX];
    swm_pkg::to_right_t        l_in  [swm_pkg::WIN_MAX];
    swm_pkg::to_left_t         r_in  [swm_pkg::WIN_MAX];
    swm_pkg::smp_t             lo_grp_reg [swm_pkg::NGRP];
    swm_pkg::smp_t             hi_grp_reg [swm_pkg::NGRP];
    swm_pkg::smp_t             lo_sel;
    swm_pkg::smp_t             hi_sel;

    always_comb
    begin
        if (ws_reg == '0)
        begin
            ws_eff = swm_pkg::CNT_W'(1);
        end
        else if (ws_reg > swm_pkg::CFG_W'(swm_pkg::WIN_MAX))
        begin
            ws_eff = swm_pkg::CNT_W'(swm_pkg::WIN_MAX);
        end
        else
        begin
            ws_eff = swm_pkg::CNT_W'(ws_reg);
        end
        mid_lo = swm_pkg::IDX_W'((ws_eff - swm_pkg::CNT_W'(1)) >> 1);
        mid_hi = swm_pkg::IDX_W'(ws_eff >> 1);
    end

    // window bookkeeping
    always_comb
    begin
        fill_e   = sample_ch.first ? '0 : fill_reg;
        full     = (fill_e == ws_eff);
        res_flag = full || ((fill_e + swm_pkg::CNT_W'(1)) == ws_eff);
        waddr    = full ? ptr_reg : fill_e[swm_pkg::IDX_W-1:0];
        if (!full)
        begin
            ptr_adv = '0;
        end
        else if ((swm_pkg::CNT_W'(ptr_reg) + swm_pkg::CNT_W'(1)) == ws_eff)
        begin
            ptr_adv = '0;
        end
        else
        begin
            ptr_adv = ptr_reg + swm_pkg::IDX_W'(1);
        end
        fill_next = full ? fill_e : fill_e + swm_pkg::CNT_W'(1);
        if (cfg_we)
        begin
            raddr    = '0;
            ptr_next = '0;
        end
        else if (in_fire)
        begin
            raddr    = ptr_adv;
            ptr_next = ptr_adv;
        end
        else
        begin
            raddr    = ptr_reg;
            ptr_next = ptr_reg;
        end
    end

    // handshake
    assign s2_load   = !o_v_reg || median_ch.ready;
    assign s1_load   = !s1_v_reg || s2_load;
    assign sample_ch.ready = !r0_v_reg || s1_load;
    assign in_fire   = sample_ch.valid && sample_ch.ready;
    assign r0_v_next = in_fire ? res_flag : (r0_v_reg && !s1_load);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg   <= swm_pkg::CFG_W'(swm_pkg::WS_RESET);
            fill_reg <= '0;
            ptr_reg  <= '0;
            r0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
            byp_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ws_reg   <= cfg_wdata;
                fill_reg <= '0;
            end
            else if (in_fire)
            begin
                fill_reg <= fill_next;
            end
            ptr_reg  <= ptr_next;
            r0_v_reg <= r0_v_next;
            byp_reg  <= in_fire && (raddr == waddr);
            if (s1_load)
            begin
                s1_v_reg <= r0_v_reg;
            end
            if (s2_load)
            begin
                o_v_reg <= s1_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byp_data_reg <= sample_ch.sample;
        end
    end

    swm_ram #(
        .WIDTH (swm_pkg::SAMPLE_W),
        .DEPTH (swm_pkg::WIN_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (in_fire),
        .waddr (waddr),
        .wdata (sample_ch.sample),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign old = byp_reg ? byp_data_reg : rdata;

    assign ctl.step = in_fire;
    assign ctl.clr  = sample_ch.first;
    assign ctl.rm   = full;
    assign ctl.wipe = cfg_we;

    // cell row, ascending from index 0
    for (genvar i = 0; i < swm_pkg::WIN_MAX; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign l_in[i] = '{ler: 1'b1, ev: 1'b1, r: '0};
        end
        else
        begin : g_mid
            assign l_in[i] = tr[i-1];
        end
        if (i == swm_pkg::WIN_MAX - 1)
        begin : g_tail
            assign r_in[i] = '{le: 1'b0, v: '0};
        end
        else
        begin : g_body
            assign r_in[i] = tl[i+1];
        end

        swm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .s        (sample_ch.sample),
            .old      (old),
            .left_in  (l_in[i]),
            .right_in (r_in[i]),
            .to_left  (tl[i]),
            .to_right (tr[i])
        );
    end

    // median select: low index bits per group, then group, then add
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            for (int g = 0; g < swm_pkg::NGRP; g++)
            begin
                lo_grp_reg[g] <= tl[swm_pkg::IDX_W'(g * swm_pkg::GRP)
                    + swm_pkg::IDX_W'(mid_lo[swm_pkg::GRP_W-1:0])].v;
                hi_grp_reg[g] <= tl[swm_pkg::IDX_W'(g * swm_pkg::GRP)
                    + swm_pkg::IDX_W'(mid_hi[swm_pkg::GRP_W-1:0])].v;
            end
        end
    end

    assign lo_sel = lo_grp_reg[mid_lo[swm_pkg::IDX_W-1:swm_pkg::GRP_W]];
    assign hi_sel = hi_grp_reg[mid_hi[swm_pkg::IDX_W-1:swm_pkg::GRP_W]];

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            o_data_reg <= swm_pkg::med_t'(lo_sel) + swm_pkg::med_t'(hi_sel);
        end
    end

    assign median_ch.valid          = o_v_reg;
    assign median_ch.median_doubled = o_data_reg;

endmodule

`default_nettype wire

// ----- hdl/swm_ram.sv -----
`default_nettype none

module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/swm_cell.sv -----
`default_nettype none

module swm_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire swm_pkg::cell_ctl_t  ctl,
    input  wire swm_pkg::smp_t       s,
    input  wire swm_pkg::smp_t       old,
    input  wire swm_pkg::to_right_t  left_in,
    input  wire swm_pkg::to_left_t   right_in,
    output swm_pkg::to_left_t        to_left,
    output swm_pkg::to_right_t       to_right
);

    logic          valid_reg;
    logic          valid_next;
    swm_pkg::smp_t v_reg;
    swm_pkg::smp_t v_next;
    logic          ev;
    logic          le;
    logic          del;
    logic          ler;
    swm_pkg::smp_t r;

    // del: this cell sits at or after the entry being dropped
    always_comb
    begin
        ev  = valid_reg && !ctl.clr;
        le  = ev && (v_reg <= s);
        del = ev && ctl.rm && (v_reg >= old);
        r   = del ? right_in.v : v_reg;
        ler = del ? right_in.le : le;
        if (ler)
        begin
            v_next = r;
        end
        else if (left_in.ler)
        begin
            v_next = s;
        end
        else
        begin
            v_next = left_in.r;
        end
        valid_next = ctl.rm ? valid_reg : (ev || left_in.ev);
    end

    assign to_left.le  = le;
    assign to_left.v   = v_reg;
    assign to_right.ler = ler;
    assign to_right.ev  = ev;
    assign to_right.r   = r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.wipe)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            v_reg <= v_next;
        end
    end

endmodule

`default_nettype wire
